### src/mdc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdc_pkg
// Shared types and constants for the keyed edge duration classifier.
// ----------------------------------------------------------------------------
package mdc_pkg;

	localparam int TimeW  = 32;
	localparam int ThreshW = 16;
	localparam int CfgIdxW = 3;
	localparam int ClassW  = 3;

	// Result classes
	typedef enum logic [ClassW-1:0] {
		CLS_DIT         = 3'd0,
		CLS_DAH         = 3'd1,
		CLS_ELEMENT_GAP = 3'd2,
		CLS_LETTER_GAP  = 3'd3,
		CLS_WORD_GAP    = 3'd4,
		CLS_NOISE       = 3'd5
	} symbol_class_t;

	// Register indexes
	typedef enum logic [CfgIdxW-1:0] {
		REG_ONE_UNIT_MIN   = 3'd0,
		REG_ONE_UNIT_MAX   = 3'd1,
		REG_THREE_UNIT_MIN = 3'd2,
		REG_THREE_UNIT_MAX = 3'd3,
		REG_SEVEN_UNIT_MIN = 3'd4
	} cfg_idx_t;

	// Register reset values
	localparam logic [ThreshW-1:0] ONE_UNIT_MIN_RST   = 16'd50;
	localparam logic [ThreshW-1:0] ONE_UNIT_MAX_RST   = 16'd150;
	localparam logic [ThreshW-1:0] THREE_UNIT_MIN_RST = 16'd250;
	localparam logic [ThreshW-1:0] THREE_UNIT_MAX_RST = 16'd450;
	localparam logic [ThreshW-1:0] SEVEN_UNIT_MIN_RST = 16'd600;

	// Threshold set handed to the classifier
	typedef struct packed {
		logic [ThreshW-1:0] one_unit_min;
		logic [ThreshW-1:0] one_unit_max;
		logic [ThreshW-1:0] three_unit_min;
		logic [ThreshW-1:0] three_unit_max;
		logic [ThreshW-1:0] seven_unit_min;
	} cfg_t;

	// Classifier verdict for one sample
	typedef struct packed {
		logic          is_edge;
		symbol_class_t cls;
		logic [TimeW-1:0] duration;
	} result_t;

endpackage

### src/mdc_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdc_cfg_regs
// Threshold register file, written through a plain write port.
// ----------------------------------------------------------------------------
module mdc_cfg_regs
	import mdc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [ThreshW-1:0] cfg_wdata,
	output cfg_t               cfg
);

	cfg_t cfg_q;

	// Register writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.one_unit_min   <= ONE_UNIT_MIN_RST;
			cfg_q.one_unit_max   <= ONE_UNIT_MAX_RST;
			cfg_q.three_unit_min <= THREE_UNIT_MIN_RST;
			cfg_q.three_unit_max <= THREE_UNIT_MAX_RST;
			cfg_q.seven_unit_min <= SEVEN_UNIT_MIN_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ONE_UNIT_MIN:   cfg_q.one_unit_min   <= cfg_wdata;
				REG_ONE_UNIT_MAX:   cfg_q.one_unit_max   <= cfg_wdata;
				REG_THREE_UNIT_MIN: cfg_q.three_unit_min <= cfg_wdata;
				REG_THREE_UNIT_MAX: cfg_q.three_unit_max <= cfg_wdata;
				REG_SEVEN_UNIT_MIN: cfg_q.seven_unit_min <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### src/mdc_classify.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdc_classify
// Edge detect, elapsed time and window compare for one sample.
// ----------------------------------------------------------------------------
module mdc_classify
	import mdc_pkg::*;
(
	input  logic             level,
	input  logic [TimeW-1:0] timestamp,
	input  logic             last_level,
	input  logic [TimeW-1:0] last_edge_time,
	input  cfg_t             cfg,
	output result_t          result
);

	logic [TimeW-1:0] dur;
	logic             in_one;
	logic             in_three;
	logic             word_gap;

	// Elapsed time wraps modulo 2^32
	assign dur = timestamp - last_edge_time;

	// Window tests against zero-extended thresholds
	assign in_one   = ({{(TimeW-ThreshW){1'b0}}, cfg.one_unit_min} <= dur) &&
	                  (dur <= {{(TimeW-ThreshW){1'b0}}, cfg.one_unit_max});
	assign in_three = ({{(TimeW-ThreshW){1'b0}}, cfg.three_unit_min} <= dur) &&
	                  (dur <= {{(TimeW-ThreshW){1'b0}}, cfg.three_unit_max});
	assign word_gap = dur >= {{(TimeW-ThreshW){1'b0}}, cfg.seven_unit_min};

	// Priority select: longest class first
	always_comb begin
		result.is_edge  = level ^ last_level;
		result.duration = dur;
		if (level) begin
			if (word_gap)      result.cls = CLS_WORD_GAP;
			else if (in_three) result.cls = CLS_LETTER_GAP;
			else if (in_one)   result.cls = CLS_ELEMENT_GAP;
			else               result.cls = CLS_NOISE;
		end else begin
			if (in_three)      result.cls = CLS_DAH;
			else if (in_one)   result.cls = CLS_DIT;
			else               result.cls = CLS_NOISE;
		end
	end

endmodule

### src/morse_edge_duration_classifier_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// morse_edge_duration_classifier_core
// Classifies on and off durations of a keyed level into dits, dahs and gaps.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries one sample: level and a
//   millisecond timestamp. Output channel (out_valid/out_stall) carries one
//   result per level edge: symbol_class and duration since the previous edge.
//   Samples that repeat the previous level produce nothing.
//   A sample lands in an input register; combinational compare and subtract
//   logic fills the result register, and out_valid rises when the sample
//   moves into it. Throughput is one sample per cycle while out_stall is low,
//   set by the single subtract/compare path between the two registers.
//   While the receiver stalls, the result register holds and one more sample
//   can wait in the input register; in_stall rises only when both are full.
//   Thresholds are written through cfg_we/cfg_index/cfg_wdata while idle.
//   Reset clears the held level to off, the edge time to zero and the
//   thresholds to 50/150/250/450/600 ms; both registers come up empty.
// ----------------------------------------------------------------------------
module morse_edge_duration_classifier_core
	import mdc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	// sample channel
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               level,
	input  logic [TimeW-1:0]   timestamp,
	// result channel
	output logic               out_valid,
	input  logic               out_stall,
	output logic [ClassW-1:0]  symbol_class,
	output logic [TimeW-1:0]   duration,
	// threshold write port
	input  logic               cfg_we,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [ThreshW-1:0] cfg_wdata
);

	cfg_t             cfg;
	result_t          res;
	logic             valid_s1;
	logic             level_s1;
	logic [TimeW-1:0] timestamp_s1;
	logic             valid_s2;
	symbol_class_t    cls_s2;
	logic [TimeW-1:0] duration_s2;
	logic             last_level_q;
	logic [TimeW-1:0] last_edge_time_q;
	logic             advance;

	mdc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	mdc_classify u_classify (
		.level          (level_s1),
		.timestamp      (timestamp_s1),
		.last_level     (last_level_q),
		.last_edge_time (last_edge_time_q),
		.cfg            (cfg),
		.result         (res)
	);

	// Stage 1 moves on whenever the result register is free or draining
	assign advance  = !valid_s2 || !out_stall;
	assign in_stall = valid_s1 && !advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			level_s1     <= level;
			timestamp_s1 <= timestamp;
		end
	end

	// Edge state, updated as an edge sample leaves stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_level_q     <= 1'b0;
			last_edge_time_q <= '0;
		end else if (valid_s1 && advance && res.is_edge) begin
			last_level_q     <= level_s1;
			last_edge_time_q <= timestamp_s1;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1 && res.is_edge;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && res.is_edge) begin
			cls_s2      <= res.cls;
			duration_s2 <= res.duration;
		end
	end

	assign out_valid    = valid_s2;
	assign symbol_class = cls_s2;
	assign duration     = duration_s2;

	// Checks
	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && valid_s2)
		else $error("input stalled without both registers full");

	a_class_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (symbol_class <= CLS_NOISE))
		else $error("result class out of range");

	a_edge_time: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && advance && res.is_edge |=>
			last_edge_time_q == $past(timestamp_s1) && last_level_q == $past(level_s1))
		else $error("edge state not taken from the edge sample");

endmodule
